>>> design/gsbs_pkg.sv
// ----------------------------------------------------------------------------
// gsbs_pkg: shared constants and types for the glyph shadow spreader
// Grid limits, field widths, register indexes and the pipeline beat record.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbs_pkg;

    localparam int MAX_GRID_WIDTH = 128;
    localparam int MAX_GRID_ROWS  = 256;
    localparam int SPREAD         = 4;
    localparam int SAT_MAX        = 255;

    localparam int COL_W      = $clog2(MAX_GRID_WIDTH);
    localparam int ROW_W      = $clog2(MAX_GRID_ROWS);
    localparam int SAMPLE_W   = 8;
    localparam int WIDTH_W    = 7;
    localparam int ROWS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CSUM_W     = 12;
    localparam int TOTAL_W    = 14;
    localparam int WORD_W     = SPREAD * SAMPLE_W;
    localparam int SLOT_W     = $clog2(SPREAD);

    localparam int WIDTH_LIMIT = MAX_GRID_WIDTH - SPREAD;
    localparam int ROWS_LIMIT  = MAX_GRID_ROWS - SPREAD;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 7'd16;
    localparam logic [ROWS_W-1:0]  ROWS_RESET   = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITMAP_WIDTH  = 2'd0,
        CFG_BITMAP_ROWS   = 2'd1,
        CFG_SHADOW_ENABLE = 2'd2
    } cfg_index_t;

    // one beat on its way from the line store read to the output register
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]    col;
        logic [SLOT_W-1:0]   slot;
        logic [SPREAD-1:0]   row_ok;
        logic                spread;
        logic                eor;
        logic                eoi;
    } beat_t;

endpackage

`default_nettype wire

>>> design/glyph_shadow_box_spread.sv
// ----------------------------------------------------------------------------
// glyph_shadow_box_spread: 5x5 saturating box spread of a glyph coverage map
// Turns a raster stream of coverage samples into soft shadow pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one coverage sample per beat, raster order over the grid.
//     In spread mode the grid is the bitmap grown by four columns and four
//     rows; samples outside the bitmap are taken as zero.
//   m_ channel: one pixel per input beat, tlast on the last pixel of a grid
//     row, tuser on the last pixel of the grid.
//   cfg_: register writes (width, rows, spread enable) restart the frame;
//     write only while the block is idle.
//   Path: a sample passes the beat register, then the output register.
//   Throughput: one beat per cycle while m_tready is high. The previous
//     four rows live in one line store word per column (four samples
//     packed), read when a beat is accepted and written back when it leaves
//     the second stage, so each column takes a single read-modify-write.
//   Reset: width and rows 16, spread on, frame at row 0, column 0. The line
//     store is not cleared; rows above the image are masked.
//   Stall: when m_tready is low the output register holds, the middle stage
//     keeps its read data, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_shadow_box_spread (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gsbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gsbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [gsbs_pkg::SAMPLE_W-1:0]      s_tdata,   // [7:0] source_sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [gsbs_pkg::SAMPLE_W-1:0]           m_tdata,   // [7:0] pixel_value
    output logic                                    m_tlast,   // end_of_row
    output logic                                    m_tuser    // [0] end_of_image
);

    localparam int COL_W    = gsbs_pkg::COL_W;
    localparam int ROW_W    = gsbs_pkg::ROW_W;
    localparam int SAMPLE_W = gsbs_pkg::SAMPLE_W;
    localparam int SPREAD   = gsbs_pkg::SPREAD;
    localparam int SLOT_W   = gsbs_pkg::SLOT_W;
    localparam int WORD_W   = gsbs_pkg::WORD_W;
    localparam int CSUM_W   = gsbs_pkg::CSUM_W;
    localparam int TOTAL_W  = gsbs_pkg::TOTAL_W;
    localparam int CMP_W    = 16;

    // configuration
    logic [gsbs_pkg::WIDTH_W-1:0] bitmap_width_reg;
    logic [gsbs_pkg::ROWS_W-1:0]  bitmap_rows_reg;
    logic                         shadow_enable_reg;
    logic                         cfg_hit;

    // effective sizes
    logic [COL_W-1:0] eff_width;
    logic [ROW_W-1:0] eff_rows;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [COL_W:0]   grid_width;
    logic [ROW_W:0]   grid_rows;

    // positions
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;

    // pipeline
    logic                 s_accept;
    logic                 b_go;
    logic                 b_valid_reg, b_valid_next;
    gsbs_pkg::beat_t      b_reg, b_next;
    logic                 a_eor, a_eoi;

    // line store: one word per column, four rows packed
    logic [WORD_W-1:0]    line_mem [gsbs_pkg::MAX_GRID_WIDTH];
    logic [WORD_W-1:0]    rd_word_reg;
    logic [WORD_W-1:0]    wr_word;

    // column sums of the four columns to the left
    logic [CSUM_W-1:0]    csum_reg  [SPREAD];
    logic [CSUM_W-1:0]    csum_next [SPREAD];
    logic [CSUM_W-1:0]    col_sum;
    logic [TOTAL_W-1:0]   total;
    logic [SAMPLE_W-1:0]  spread_pixel;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]  m_data_reg;
    logic                 m_last_reg;
    logic                 m_user_reg;

    assign cfg_hit = cfg_wr_en && (cfg_index == gsbs_pkg::CFG_BITMAP_WIDTH ||
                                   cfg_index == gsbs_pkg::CFG_BITMAP_ROWS ||
                                   cfg_index == gsbs_pkg::CFG_SHADOW_ENABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_width_reg  <= gsbs_pkg::WIDTH_RESET;
            bitmap_rows_reg   <= gsbs_pkg::ROWS_RESET;
            shadow_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gsbs_pkg::CFG_BITMAP_WIDTH: begin
                    bitmap_width_reg <= cfg_wdata[gsbs_pkg::WIDTH_W-1:0];
                end
                gsbs_pkg::CFG_BITMAP_ROWS: begin
                    bitmap_rows_reg <= cfg_wdata[gsbs_pkg::ROWS_W-1:0];
                end
                gsbs_pkg::CFG_SHADOW_ENABLE: begin
                    shadow_enable_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp sizes to 1..limit
    always_comb begin
        if (bitmap_width_reg == '0) begin
            eff_width = COL_W'(1);
        end else if (CMP_W'(bitmap_width_reg) > CMP_W'(gsbs_pkg::WIDTH_LIMIT)) begin
            eff_width = COL_W'(gsbs_pkg::WIDTH_LIMIT);
        end else begin
            eff_width = COL_W'(bitmap_width_reg);
        end
        if (bitmap_rows_reg == '0) begin
            eff_rows = ROW_W'(1);
        end else if (CMP_W'(bitmap_rows_reg) > CMP_W'(gsbs_pkg::ROWS_LIMIT)) begin
            eff_rows = ROW_W'(gsbs_pkg::ROWS_LIMIT);
        end else begin
            eff_rows = ROW_W'(bitmap_rows_reg);
        end
        grid_width = {1'b0, eff_width} + (shadow_enable_reg ? (COL_W+1)'(SPREAD) : '0);
        grid_rows  = {1'b0, eff_rows} + (shadow_enable_reg ? (ROW_W+1)'(SPREAD) : '0);
        last_col   = COL_W'(grid_width - (COL_W+1)'(1));
        last_row   = ROW_W'(grid_rows - (ROW_W+1)'(1));
    end

    // handshake
    assign b_go     = b_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_go;
    assign s_accept = s_tvalid && s_tready;

    // first stage: position, masking and line store read address
    always_comb begin
        a_eor = (col_pos_reg == last_col);
        a_eoi = a_eor && (row_pos_reg == last_row);

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (s_accept) begin
            if (a_eor) begin
                col_pos_next = '0;
                row_pos_next = a_eoi ? '0 : row_pos_reg + ROW_W'(1);
            end else begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
        if (cfg_hit) begin
            col_pos_next = '0;
            row_pos_next = '0;
        end

        b_next.sample = (col_pos_reg < eff_width && row_pos_reg < eff_rows) ?
                        s_tdata : '0;
        if (!shadow_enable_reg) begin
            b_next.sample = s_tdata;
        end
        b_next.col    = col_pos_reg;
        b_next.slot   = row_pos_reg[SLOT_W-1:0];
        for (int k = 0; k < SPREAD; k++) begin
            b_next.row_ok[k] = (row_pos_reg > ROW_W'(k));
        end
        b_next.spread = shadow_enable_reg;
        b_next.eor    = a_eor;
        b_next.eoi    = a_eoi;

        b_valid_next = b_valid_reg;
        if (s_accept) begin
            b_valid_next = 1'b1;
        end else if (b_go) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_reg <= b_next;
        end
    end

    // line store: read on accept, write back from the second stage
    always_ff @(posedge aclk) begin
        if (s_accept && shadow_enable_reg) begin
            rd_word_reg <= line_mem[col_pos_reg];
        end
        if (b_go && b_reg.spread) begin
            line_mem[b_reg.col] <= wr_word;
        end
    end

    // second stage: column sum, window sum, saturation
    always_comb begin
        logic [SLOT_W-1:0] rslot;
        col_sum = CSUM_W'(b_reg.sample);
        for (int k = 0; k < SPREAD; k++) begin
            rslot = b_reg.slot - SLOT_W'(k + 1);
            if (b_reg.row_ok[k]) begin
                col_sum = col_sum + CSUM_W'(rd_word_reg[rslot*SAMPLE_W +: SAMPLE_W]);
            end
        end
        for (int j = 0; j < SPREAD; j++) begin
            wr_word[j*SAMPLE_W +: SAMPLE_W] = (b_reg.slot == SLOT_W'(j)) ?
                b_reg.sample : rd_word_reg[j*SAMPLE_W +: SAMPLE_W];
        end
        total = TOTAL_W'(col_sum);
        for (int j = 0; j < SPREAD; j++) begin
            total = total + TOTAL_W'(csum_reg[j]);
        end
        spread_pixel = (total > TOTAL_W'(gsbs_pkg::SAT_MAX)) ?
                       SAMPLE_W'(gsbs_pkg::SAT_MAX) : total[SAMPLE_W-1:0];

        for (int j = 0; j < SPREAD; j++) begin
            csum_next[j] = csum_reg[j];
        end
        if (b_go && b_reg.spread) begin
            csum_next[0] = col_sum;
            for (int j = 1; j < SPREAD; j++) begin
                csum_next[j] = csum_reg[j-1];
            end
        end
        // left edge of each row and frame restart see empty columns
        if ((b_go && b_reg.eor) || cfg_hit) begin
            for (int j = 0; j < SPREAD; j++) begin
                csum_next[j] = '0;
            end
        end

        m_valid_next = m_valid_reg;
        if (b_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SPREAD; j++) begin
                csum_reg[j] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            for (int j = 0; j < SPREAD; j++) begin
                csum_reg[j] <= csum_next[j];
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            m_data_reg <= b_reg.spread ? spread_pixel : b_reg.sample;
            m_last_reg <= b_reg.eor;
            m_user_reg <= b_reg.eoi;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire
